FILE: rtl/core/ccsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccsa_pkg
// Shared widths, calendar constants and types for the calendar clock adder.
// ----------------------------------------------------------------------------
package ccsa_pkg;

  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned MdayW  = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned AddW   = 10;
  localparam int unsigned AccW   = 11;   // second + add, up to 1086
  localparam int unsigned MinAccW = 7;   // minute + carries, up to 81
  localparam int unsigned AluW   = 16;

  localparam logic [AluW-1:0] SecPerMin  = 16'd60;
  localparam logic [AluW-1:0] MinPerHour = 16'd60;
  localparam logic [AluW-1:0] LastHour   = 16'd23;
  localparam logic [AluW-1:0] LastMonth  = 16'd12;
  localparam logic [WdayW-1:0] LastWday  = 3'd7;
  // adding one to the year is done as subtracting all ones
  localparam logic [AluW-1:0] MinusOne   = 16'hFFFF;

  // y divisible by 25  <=>  (y * inverse of 25 mod 2^16) <= floor(65535 / 25)
  localparam logic [YearW-1:0] Inv25    = 16'h5C29;
  localparam logic [YearW-1:0] Div25Max = 16'd2621;

  typedef struct packed {
    logic            ge;    // a >= b
    logic [AluW-1:0] diff;  // a - b, modulo 2^16
  } alu_res_t;

  // month length; months outside 1..12 count as 31 days
  function automatic logic [MdayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                  input logic leap);
    logic [MdayW-1:0] n;
    begin
      unique case (month)
        4'd2:    n = leap ? 5'd29 : 5'd28;
        4'd4:    n = 5'd30;
        4'd6:    n = 5'd30;
        4'd9:    n = 5'd30;
        4'd11:   n = 5'd30;
        default: n = 5'd31;
      endcase
      return n;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ccsa_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccsa_alu
// Shared compare-and-subtract unit: one 16-bit subtractor with borrow out.
// ----------------------------------------------------------------------------
module ccsa_alu
  import ccsa_pkg::*;
(
  input  logic [AluW-1:0] a_i,
  input  logic [AluW-1:0] b_i,
  output alu_res_t        res_o
);

  logic [AluW:0] sub;

  assign sub         = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff  = sub[AluW-1:0];
  assign res_o.ge    = ~sub[AluW];

endmodule
`default_nettype wire

FILE: rtl/core/calendar_clock_seconds_adder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_clock_seconds_adder_unit
// Calendar clock (sec/min/hour/weekday/day/month/year) with a seconds adder.
// ----------------------------------------------------------------------------
// Sequence: a load goes to S_FLAG, then S_OUT. An advance runs S_SEC, which
//   peels 60 s per pass, then S_MIN and, while carries are taken, S_HOUR,
//   S_DAY, S_MON and S_YEAR in turn, then S_FLAG and S_OUT.
// Flow: one transaction at a time, in_stall_o high until the result is taken.
// Reset: async, active low; time 00:00:00, weekday 1, day 1, month 1, year 0.
// ----------------------------------------------------------------------------
module calendar_clock_seconds_adder_unit
  import ccsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [AddW-1:0]   add_seconds_i,
  input  logic [SecW-1:0]   load_second_i,
  input  logic [MinW-1:0]   load_minute_i,
  input  logic [HourW-1:0]  load_hour_i,
  input  logic [WdayW-1:0]  load_weekday_i,
  input  logic [MdayW-1:0]  load_day_i,
  input  logic [MonthW-1:0] load_month_i,
  input  logic [YearW-1:0]  load_year_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SecW-1:0]   sec_out_o,
  output logic [MinW-1:0]   min_out_o,
  output logic [HourW-1:0]  hour_out_o,
  output logic [WdayW-1:0]  wday_out_o,
  output logic [MdayW-1:0]  mday_out_o,
  output logic [MonthW-1:0] month_out_o,
  output logic [YearW-1:0]  year_out_o,
  output logic              at_ten_min_o,
  output logic              at_half_hour_o,
  output logic              at_hour_o,
  output logic              at_day_o,
  output logic              at_month_o
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;  // waiting for a transaction
  localparam logic [3:0] S_SEC  = 4'd1;  // peel 60 s per cycle into minutes
  localparam logic [3:0] S_MIN  = 4'd2;  // single hour carry check
  localparam logic [3:0] S_HOUR = 4'd3;  // day rollover check, leap calc
  localparam logic [3:0] S_DAY  = 4'd4;  // month length check
  localparam logic [3:0] S_MON  = 4'd5;  // year carry check
  localparam logic [3:0] S_YEAR = 4'd6;  // year + 1, wraps at 16 bits
  localparam logic [3:0] S_FLAG = 4'd7;  // boundary flags from new time
  localparam logic [3:0] S_OUT  = 4'd8;  // result held until taken

  typedef struct packed {
    logic ten_min;
    logic half_hour;
    logic hour;
    logic day;
    logic month;
  } flags_t;

  logic [3:0]         state_q, state_d;
  logic [SecW-1:0]    sec_q, sec_d;
  logic [MinW-1:0]    min_q, min_d;
  logic [HourW-1:0]   hour_q, hour_d;
  logic [WdayW-1:0]   wday_q, wday_d;
  logic [MdayW-1:0]   mday_q, mday_d;
  logic [MonthW-1:0]  month_q, month_d;
  logic [YearW-1:0]   year_q, year_d;
  // work registers, payload only
  logic [AccW-1:0]    acc_q, acc_d;
  logic [MinAccW-1:0] min_acc_q, min_acc_d;
  logic               leap_q, leap_d;
  flags_t             flags_q, flags_d;

  logic [AluW-1:0]    alu_a, alu_b;
  alu_res_t           alu_res;

  logic [YearW-1:0]   year_x_inv25;
  logic               year_div25;
  logic               year_leap;
  flags_t             flags_now;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Gregorian leap rule without a divider: divisibility by 25 through the
  // modular inverse, combined with the low bits for /4 and /16.
  assign year_x_inv25 = year_q * Inv25;
  assign year_div25   = (year_x_inv25 <= Div25Max);
  assign year_leap    = ((year_q[1:0] == 2'd0) && !year_div25) ||
                        ((year_q[3:0] == 4'd0) && year_div25);

  // boundary flags, chained as the caller tests them
  always_comb begin
    flags_now.ten_min   = (sec_q == '0) &&
                          ((min_q == 6'd0)  || (min_q == 6'd10) || (min_q == 6'd20) ||
                           (min_q == 6'd30) || (min_q == 6'd40) || (min_q == 6'd50) ||
                           (min_q == 6'd60));
    flags_now.half_hour = flags_now.ten_min &&
                          ((min_q == 6'd0) || (min_q == 6'd30) || (min_q == 6'd60));
    flags_now.hour      = flags_now.half_hour && (min_q == 6'd0);
    flags_now.day       = flags_now.hour && (hour_q == '0);
    flags_now.month     = flags_now.day && (mday_q == 5'd1);
  end

  // operand select for the shared subtractor
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_q)
      S_SEC: begin
        alu_a = {{(AluW-AccW){1'b0}}, acc_q};
        alu_b = SecPerMin;
      end
      S_MIN: begin
        alu_a = {{(AluW-MinAccW){1'b0}}, min_acc_q};
        alu_b = MinPerHour;
      end
      S_HOUR: begin
        alu_a = {{(AluW-HourW){1'b0}}, hour_q};
        alu_b = LastHour;
      end
      S_DAY: begin
        alu_a = {{(AluW-MdayW){1'b0}}, mday_q};
        alu_b = {{(AluW-MdayW){1'b0}}, month_days(month_q, leap_q)};
      end
      S_MON: begin
        alu_a = {{(AluW-MonthW){1'b0}}, month_q};
        alu_b = LastMonth;
      end
      S_YEAR: begin
        alu_a = year_q;
        alu_b = MinusOne;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  ccsa_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    wday_d    = wday_q;
    mday_d    = mday_q;
    month_d   = month_q;
    year_d    = year_q;
    acc_d     = acc_q;
    min_acc_d = min_acc_q;
    leap_d    = leap_q;
    flags_d   = flags_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_i) begin
            sec_d   = load_second_i;
            min_d   = load_minute_i;
            hour_d  = load_hour_i;
            wday_d  = load_weekday_i;
            mday_d  = load_day_i;
            month_d = load_month_i;
            year_d  = load_year_i;
            state_d = S_FLAG;
          end else begin
            acc_d     = {{(AccW-SecW){1'b0}}, sec_q} + {{(AccW-AddW){1'b0}}, add_seconds_i};
            min_acc_d = {1'b0, min_q};
            state_d   = S_SEC;
          end
        end
      end
      S_SEC: begin
        if (alu_res.ge) begin
          acc_d     = alu_res.diff[AccW-1:0];
          min_acc_d = min_acc_q + 7'd1;
        end else begin
          sec_d   = acc_q[SecW-1:0];
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        if (alu_res.ge) begin
          min_d   = alu_res.diff[MinW-1:0];
          state_d = S_HOUR;
        end else begin
          min_d   = min_acc_q[MinW-1:0];
          state_d = S_FLAG;
        end
      end
      S_HOUR: begin
        leap_d = year_leap;
        if (alu_res.ge) begin
          hour_d  = '0;
          wday_d  = ((wday_q == '0) || (wday_q == LastWday)) ? 3'd1 : wday_q + 3'd1;
          state_d = S_DAY;
        end else begin
          hour_d  = hour_q + 5'd1;
          state_d = S_FLAG;
        end
      end
      S_DAY: begin
        if (alu_res.ge) begin
          mday_d  = 5'd1;
          state_d = S_MON;
        end else begin
          mday_d  = mday_q + 5'd1;
          state_d = S_FLAG;
        end
      end
      S_MON: begin
        if (alu_res.ge) begin
          month_d = 4'd1;
          state_d = S_YEAR;
        end else begin
          month_d = month_q + 4'd1;
          state_d = S_FLAG;
        end
      end
      S_YEAR: begin
        year_d  = alu_res.diff;
        state_d = S_FLAG;
      end
      S_FLAG: begin
        flags_d = flags_now;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control, time and date state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      wday_q  <= 3'd1;
      mday_q  <= 5'd1;
      month_q <= 4'd1;
      year_q  <= '0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      wday_q  <= wday_d;
      mday_q  <= mday_d;
      month_q <= month_d;
      year_q  <= year_d;
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    min_acc_q <= min_acc_d;
    leap_q    <= leap_d;
    flags_q   <= flags_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign sec_out_o      = sec_q;
  assign min_out_o      = min_q;
  assign hour_out_o     = hour_q;
  assign wday_out_o     = wday_q;
  assign mday_out_o     = mday_q;
  assign month_out_o    = month_q;
  assign year_out_o     = year_q;
  assign at_ten_min_o   = flags_q.ten_min;
  assign at_half_hour_o = flags_q.half_hour;
  assign at_hour_o      = flags_q.hour;
  assign at_day_o       = flags_q.day;
  assign at_month_o     = flags_q.month;

endmodule
`default_nettype wire

FILE: rtl/core/ccsa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccsa_checker
// Port-level checks for the calendar clock adder, bound to the top level.
// ----------------------------------------------------------------------------
module ccsa_checker
  import ccsa_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [SecW-1:0]   sec_out_o,
  input wire logic [MinW-1:0]   min_out_o,
  input wire logic [YearW-1:0]  year_out_o,
  input wire logic              at_ten_min_o,
  input wire logic              at_half_hour_o,
  input wire logic              at_hour_o,
  input wire logic              at_day_o,
  input wire logic              at_month_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sec_out_o) &&
      $stable(min_out_o) && $stable(year_out_o))
    else $error("stalled result changed");

  // one transaction in flight: busy while a result is pending
  a_busy_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  // an accepted transaction keeps the input stalled next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("not busy after accepting a transaction");

  // boundary flags nest
  a_flag_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!at_ten_min_o || (sec_out_o == '0)) &&
      (!at_half_hour_o || at_ten_min_o) && (!at_hour_o || at_half_hour_o) &&
      (!at_day_o || at_hour_o) && (!at_month_o || at_day_o))
    else $error("boundary flags inconsistent");

endmodule

bind calendar_clock_seconds_adder_unit ccsa_checker u_ccsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sec_out_o      (sec_out_o),
  .min_out_o      (min_out_o),
  .year_out_o     (year_out_o),
  .at_ten_min_o   (at_ten_min_o),
  .at_half_hour_o (at_half_hour_o),
  .at_hour_o      (at_hour_o),
  .at_day_o       (at_day_o),
  .at_month_o     (at_month_o)
);
`default_nettype wire
